// File: design/sscc_pkg.sv
// ----------------------------------------------------------------------------
// sscc_pkg: shared types and functions of the section CRC checker
// Holds the result codes, table classes, the stage structs, the byte-wide
// MPEG-2 CRC-32 update and the table id classifier.
// ----------------------------------------------------------------------------
package sscc_pkg;

    localparam int unsigned LenW   = 12;
    localparam int unsigned CountW = 13;
    localparam int unsigned CrcW   = 32;

    localparam logic [CrcW-1:0] CrcPoly = 32'h04C1_1DB7;
    localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;
    localparam logic [3:0]      LenHiMask = 4'hF;

    localparam logic [7:0] TidNitActual = 8'h40;
    localparam logic [7:0] TidNitOther  = 8'h41;
    localparam logic [7:0] TidSdtActual = 8'h42;
    localparam logic [7:0] TidSdtOther  = 8'h46;
    localparam logic [7:0] TidBat       = 8'h4A;

    // Header is table id plus two length bytes.
    localparam logic [CountW-1:0] HdrBytes = 13'd3;

    localparam logic [1:0] StatusOk         = 2'd0;
    localparam logic [1:0] StatusCrcFail    = 2'd1;
    localparam logic [1:0] StatusIncomplete = 2'd2;

    localparam logic [1:0] ClassNit     = 2'd0;
    localparam logic [1:0] ClassSdt     = 2'd1;
    localparam logic [1:0] ClassBat     = 2'd2;
    localparam logic [1:0] ClassUnknown = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        table_id;
        logic [1:0]        table_class;
        logic [CountW-1:0] consumed_length;
        logic              crc_mismatch;
    } t_result;

    typedef struct packed {
        logic    has_result;
        t_result result;
    } t_result_req;

    // MSB-first CRC-32 over one byte, no reflection.
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                                 input logic [7:0] data);
        logic [CrcW-1:0] c;
        c = crc_in ^ {data, 24'h00_0000};
        for (int i = 0; i < 8; i++) begin
            if (c[CrcW-1]) begin
                c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[CrcW-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [1:0] classify(input logic [7:0] tid);
        logic [1:0] cls;
        unique case (tid)
            TidNitActual, TidNitOther: cls = ClassNit;
            TidSdtActual, TidSdtOther: cls = ClassSdt;
            TidBat:                    cls = ClassBat;
            default:                   cls = ClassUnknown;
        endcase
        return cls;
    endfunction

endpackage

// File: design/si_section_crc_checker.sv
// ----------------------------------------------------------------------------
// si_section_crc_checker: MPEG-2 PSI/SI section CRC-32 checker
// Checks one section per buffer, one byte per transaction, and reports
// status, table id, table class and consumed length per section.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  --------  ---------  ------------------  ----------------------------------
//  input     in         i_valid / o_stall   i_data_byte, i_end_of_buffer
//  result    out        o_valid / i_stall   o_status, o_table_id, o_table_class,
//                                           o_consumed_length, o_crc_mismatch
//  config    in         i_cfg_wr_en         i_cfg_wr_data (crc_check_enable)
//
// One byte is taken every cycle unless o_stall holds the input register. A
// byte sits in the input register while the byte-wide CRC update and the
// section bookkeeping run; its result is then loaded into the output
// register.
// Reset is synchronous and active low; it clears the section state and sets
// the CRC check enable to one.
// A stall on the result side only holds back bytes that produce a result;
// the output register lets the next byte enter while a result waits.
//
// The design has three parts: an input register, the section stage (header
// capture, CRC-32 update, completion and early-end detection) and a result
// register. Trailing bytes after a completed section are dropped until the
// buffer end without any output.
// ----------------------------------------------------------------------------
module si_section_crc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,

    // Byte input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,

    // Result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_table_id,
    output logic [1:0]  o_table_class,
    output logic [12:0] o_consumed_length,
    output logic        o_crc_mismatch
);
    import sscc_pkg::*;

    t_in_item    in_item;
    t_in_item    stage_item;
    logic        stage_valid;
    logic        consume;
    logic        out_free;
    t_result_req req;
    t_result     result;

    assign in_item.data_byte     = i_data_byte;
    assign in_item.end_of_buffer = i_end_of_buffer;

    sscc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (in_item),
        .o_stall      (o_stall),
        .i_consume    (consume),
        .o_item_valid (stage_valid),
        .o_item       (stage_item)
    );

    // The section stage advances only when its byte can be retired: either it
    // gives no result, or the result register has room this cycle.
    sscc_section u_section (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item_valid  (stage_valid),
        .i_item        (stage_item),
        .i_out_free    (out_free),
        .o_consume     (consume),
        .o_req         (req)
    );

    sscc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (consume),
        .i_req    (req),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign o_status          = result.status;
    assign o_table_id        = result.table_id;
    assign o_table_class     = result.table_class;
    assign o_consumed_length = result.consumed_length;
    assign o_crc_mismatch    = result.crc_mismatch;

endmodule

// File: design/sscc_in_reg.sv
// ----------------------------------------------------------------------------
// sscc_in_reg: input register of the section CRC checker
// Captures one byte transaction per cycle while it is free, and holds it
// until the section stage consumes it.
// ----------------------------------------------------------------------------
module sscc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sscc_pkg::t_in_item i_item,
    output logic              o_stall,
    input  logic              i_consume,
    output logic              o_item_valid,
    output sscc_pkg::t_in_item o_item
);
    import sscc_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     load;

    // The register is free when empty or drained in this same cycle.
    assign load    = !r_valid || i_consume;
    assign o_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// File: design/sscc_section.sv
// ----------------------------------------------------------------------------
// sscc_section: section tracker and CRC-32 update
// Captures the header, runs the CRC one byte per cycle unless a result waits
// on the output, and decides when a section completes or a buffer ends early.
// ----------------------------------------------------------------------------
module sscc_section (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 i_item_valid,
    input  sscc_pkg::t_in_item   i_item,
    input  logic                 i_out_free,
    output logic                 o_consume,
    output sscc_pkg::t_result_req o_req
);
    import sscc_pkg::*;

    logic [CrcW-1:0]   r_crc,     n_crc;
    logic [CountW-1:0] r_count,   n_count;
    logic [7:0]        r_tid,     n_tid;
    logic [LenW-1:0]   r_len,     n_len;
    logic              r_done,    n_done;
    logic              r_crc_check_enable;

    logic [CrcW-1:0]   crc_upd;
    logic [CountW-1:0] target;
    logic              complete;
    logic              mismatch;
    logic              fail;

    always_comb begin
        n_crc   = r_crc;
        n_count = r_count;
        n_tid   = r_tid;
        n_len   = r_len;
        n_done  = r_done;
        o_req   = '0;

        crc_upd  = crc_byte(r_crc, i_item.data_byte);
        target   = '0;
        complete = 1'b0;
        mismatch = (crc_upd != '0);
        fail     = mismatch && r_crc_check_enable;

        if (r_done) begin
            if (i_item.end_of_buffer) begin
                n_done = 1'b0;
            end
        end else begin
            case (r_count)
                13'd0:   n_tid = i_item.data_byte;
                13'd1:   n_len = {i_item.data_byte[3:0] & LenHiMask, 8'h00};
                13'd2:   n_len = {r_len[LenW-1:8], i_item.data_byte};
                default: n_len = r_len;
            endcase
            n_crc   = crc_upd;
            n_count = r_count + 13'd1;
            target  = {1'b0, n_len} + HdrBytes;
            complete = (n_count >= HdrBytes) && (n_count == target);

            if (complete) begin
                o_req.has_result             = 1'b1;
                o_req.result.status          = fail ? StatusCrcFail : StatusOk;
                o_req.result.table_id        = r_tid;
                o_req.result.table_class     = classify(r_tid);
                o_req.result.consumed_length = fail ? '0 : target;
                o_req.result.crc_mismatch    = mismatch;
                n_done = !i_item.end_of_buffer;
            end else if (i_item.end_of_buffer) begin
                o_req.has_result             = 1'b1;
                o_req.result.status          = StatusIncomplete;
                o_req.result.table_id        = '0;
                o_req.result.table_class     = ClassUnknown;
                o_req.result.consumed_length = '0;
                o_req.result.crc_mismatch    = 1'b0;
            end
        end

        // A buffer end always returns the section state to its idle values.
        if (i_item.end_of_buffer) begin
            n_crc   = CrcInit;
            n_count = '0;
            n_tid   = '0;
            n_len   = '0;
        end
    end

    // Bytes that give no result never wait on the output side.
    assign o_consume = i_item_valid && (i_out_free || !o_req.has_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CrcInit;
            r_count <= '0;
            r_tid   <= '0;
            r_len   <= '0;
            r_done  <= 1'b0;
        end else if (o_consume) begin
            r_crc   <= n_crc;
            r_count <= n_count;
            r_tid   <= n_tid;
            r_len   <= n_len;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_check_enable <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_crc_check_enable <= i_cfg_wr_data;
        end
    end

endmodule

// File: design/sscc_out_reg.sv
// ----------------------------------------------------------------------------
// sscc_out_reg: result register of the section CRC checker
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module sscc_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sscc_pkg::t_result_req i_req,
    input  logic                  i_stall,
    output logic                  o_free,
    output logic                  o_valid,
    output sscc_pkg::t_result     o_result
);
    import sscc_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    take;

    assign o_free = !r_valid || !i_stall;
    assign take   = i_load && i_req.has_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= i_req.result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: design/sscc_checker.sv
// ----------------------------------------------------------------------------
// sscc_checker: port-level checks of the section CRC checker
// Watches the result channel and checks the consistency of each result.
// ----------------------------------------------------------------------------
module sscc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [7:0]  o_table_id,
    input logic [1:0]  o_table_class,
    input logic [12:0] o_consumed_length,
    input logic        o_crc_mismatch
);
    import sscc_pkg::*;

    // An incomplete buffer reports a fixed, empty result.
    a_incomplete_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == StatusIncomplete) |->
            (o_table_id == 8'h00 && o_table_class == ClassUnknown &&
             o_consumed_length == '0 && !o_crc_mismatch))
        else $error("incomplete result carries nonzero fields");

    // A good section reports a length covering at least the header.
    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == StatusOk) |->
            (o_consumed_length >= HdrBytes && o_consumed_length <= 13'd4098))
        else $error("ok result has out-of-range consumed length");

    // A CRC failure always comes with a mismatch flag and no length.
    a_fail_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == StatusCrcFail) |->
            (o_crc_mismatch && o_consumed_length == '0))
        else $error("CRC failure without mismatch flag or with a length");

    // The class always agrees with the reported table id for finished sections.
    a_class_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != StatusIncomplete) |->
            (o_table_class == classify(o_table_id)))
        else $error("table class does not match table id");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_status) && $stable(o_table_id) &&
             $stable(o_consumed_length)))
        else $error("stalled result changed");

endmodule

bind si_section_crc_checker sscc_checker u_sscc_checker (.*);

// File: tb/sv/tb_si_section_crc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_si_section_crc_checker: self-checking bench for the section CRC checker
// Feeds buffers of section bytes, both well-formed sections with a correct
// CRC-32 and damaged, truncated or noisy ones. A scoreboard predicts the
// per-section verdicts and matches them against every result transaction.
// ----------------------------------------------------------------------------

import sscc_pkg::*;

// Tracks the section being parsed, predicts the verdict of every section and
// keeps the verdicts that are still waiting for their result transaction.
class section_tracker;
    logic        check_en;
    logic [31:0] crc;
    int unsigned count;
    logic [7:0]  tid;
    logic [11:0] len;
    bit          done;
    t_result     pending_verdicts[$];
    int unsigned verdicts_seen;
    int unsigned fail_count;

    function new();
        restart_section();
        check_en      = 1'b1;
        verdicts_seen = 0;
        fail_count    = 0;
    endfunction

    // Byte-wide MPEG-2 CRC-32, most significant bit first.
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {b, 24'h00_0000};
        for (int i = 0; i < 8; i++) begin
            if (r[31]) begin
                r = {r[30:0], 1'b0} ^ CrcPoly;
            end else begin
                r = {r[30:0], 1'b0};
            end
        end
        return r;
    endfunction

    static function logic [1:0] class_of(logic [7:0] id);
        if (id == TidNitActual || id == TidNitOther) begin
            return ClassNit;
        end else if (id == TidSdtActual || id == TidSdtOther) begin
            return ClassSdt;
        end else if (id == TidBat) begin
            return ClassBat;
        end
        return ClassUnknown;
    endfunction

    function void restart_section();
        crc   = CrcInit;
        count = 0;
        tid   = 8'h00;
        len   = '0;
        done  = 1'b0;
    endfunction

    function int unsigned pending();
        return pending_verdicts.size();
    endfunction

    // Called for every accepted input transaction.
    function void take_byte(logic [7:0] b, logic eob);
        t_result v;
        if (done) begin
            if (eob) begin
                restart_section();
            end
            return;
        end
        case (count)
            0: tid = b;
            1: len = {b[3:0], 8'h00};
            2: len[7:0] = b;
            default: ;
        endcase
        crc = crc_step(crc, b);
        count++;
        if (count >= 3 && count == len + 3) begin
            v.crc_mismatch    = (crc != '0);
            v.status          = (v.crc_mismatch && check_en) ? StatusCrcFail : StatusOk;
            v.table_id        = tid;
            v.table_class     = class_of(tid);
            v.consumed_length = (v.status == StatusOk) ? {1'b0, len} + HdrBytes : '0;
            pending_verdicts.push_back(v);
            if (eob) begin
                restart_section();
            end else begin
                done = 1'b1;
            end
        end else if (eob) begin
            v.status          = StatusIncomplete;
            v.table_id        = 8'h00;
            v.table_class     = ClassUnknown;
            v.consumed_length = '0;
            v.crc_mismatch    = 1'b0;
            pending_verdicts.push_back(v);
            restart_section();
        end
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH %s in verdict %0d: got %0d, expected %0d",
                 what, verdicts_seen, got, want);
        fail_count++;
    endtask

    // Called for every accepted result transaction.
    task match_verdict(t_result got);
        t_result want;
        if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected result, status", got.status, 0);
            return;
        end
        want = pending_verdicts.pop_front();
        if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
        if (got.table_id != want.table_id)
            report_mismatch("table_id", got.table_id, want.table_id);
        if (got.table_class != want.table_class)
            report_mismatch("table_class", got.table_class, want.table_class);
        if (got.consumed_length != want.consumed_length)
            report_mismatch("consumed_length", got.consumed_length, want.consumed_length);
        if (got.crc_mismatch != want.crc_mismatch)
            report_mismatch("crc_mismatch", got.crc_mismatch, want.crc_mismatch);
        verdicts_seen++;
    endtask
endclass

module tb_si_section_crc_checker;

    // Cycles without any transaction on either channel before the run is
    // declared hung. The slowest correct cases are long sender gaps and long
    // receiver stalls, so this is a wide margin.
    localparam int unsigned QuietLimit  = 1000;
    // Cycles waited after the last verdict so that a trailing byte that gives
    // no result has left the pipe.
    localparam int unsigned DrainCycles = 6;
    localparam int unsigned PhaseBytes  = 150;
    localparam int unsigned PhaseCount  = 8;
    localparam int unsigned LongSecLen  = 500;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic        i_cfg_wr_data   = 1'b0;
    logic        i_valid         = 1'b0;
    logic [7:0]  i_data_byte     = 8'h00;
    logic        i_end_of_buffer = 1'b0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_table_id;
    logic [1:0]  o_table_class;
    logic [12:0] o_consumed_length;
    logic        o_crc_mismatch;

    section_tracker tracker = new();

    // Idle and stall pressure, changed from phase to phase.
    int unsigned idle_pct  = 25;
    int unsigned stall_pct = 25;
    int unsigned bytes_sent = 0;

    // The buffer that is being built and then sent, one byte per transaction.
    logic [7:0] frame_bytes[$];

    // Receiver and watchdog state.
    t_result     seen_verdict;
    int unsigned stall_run   = 0;
    logic        stall_level = 1'b0;
    int unsigned quiet_cycles = 0;

    si_section_crc_checker DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_buffer   (i_end_of_buffer),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_table_id        (o_table_id),
        .o_table_class     (o_table_class),
        .o_consumed_length (o_consumed_length),
        .o_crc_mismatch    (o_crc_mismatch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Most gaps are short, about one in ten is long.
    function automatic int unsigned pick_gap(int unsigned pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    // Section lengths are mostly small; a few reach a few hundred bytes.
    function automatic int unsigned pick_len();
        return ($urandom_range(0, 39) == 0) ? $urandom_range(41, 300) : $urandom_range(4, 40);
    endfunction

    // Table ids lean toward the classified ones so every class shows up often.
    function automatic logic [7:0] pick_tid();
        case ($urandom_range(0, 7))
            0:       return TidNitActual;
            1:       return TidNitOther;
            2:       return TidSdtActual;
            3:       return TidSdtOther;
            4:       return TidBat;
            default: return 8'($urandom);
        endcase
    endfunction

    // Result side. Every accepted result goes to the scoreboard. The stall
    // pattern alternates free runs with stall runs, mostly short, some long.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_verdict.status          = o_status;
            seen_verdict.table_id        = o_table_id;
            seen_verdict.table_class     = o_table_class;
            seen_verdict.consumed_length = o_consumed_length;
            seen_verdict.crc_mismatch    = o_crc_mismatch;
            tracker.match_verdict(seen_verdict);
        end
        if (stall_run == 0) begin
            if ($urandom_range(0, 99) < stall_pct) begin
                stall_level = 1'b1;
                stall_run   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end else begin
                stall_level = 1'b0;
                stall_run   = $urandom_range(1, 8);
            end
        end
        stall_run--;
        i_stall <= stall_level;
    end

    // A run that stops moving on both channels is hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("tb_si_section_crc_checker failed");
            $finish;
        end
    end

    // One input transaction: an optional gap, then the byte is held until the
    // block takes it. Valid stays high across back-to-back bytes, so it gets
    // a single nonblocking assignment per clock edge.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int unsigned gap;
        gap = pick_gap(idle_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        tracker.take_byte(b, eob);
        bytes_sent++;
    endtask

    // Sends the built buffer, marking its last byte as the buffer end.
    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
    endtask

    // Builds a section of the given length. From a length of four on, the
    // last four bytes carry the CRC so that the remainder comes out zero;
    // shorter sections are filled with random bytes only. The upper nibble
    // of the second byte is random since the block must ignore it.
    task automatic build_section(input logic [7:0] tid, input int unsigned len);
        int unsigned n_body;
        logic [31:0] crc;
        frame_bytes.delete();
        frame_bytes.push_back(tid);
        frame_bytes.push_back({4'($urandom), 4'(len >> 8)});
        frame_bytes.push_back(8'(len));
        n_body = (len >= 4) ? len - 4 : len;
        repeat (n_body) frame_bytes.push_back(8'($urandom));
        if (len >= 4) begin
            crc = CrcInit;
            foreach (frame_bytes[i]) begin
                crc = tracker.crc_step(crc, frame_bytes[i]);
            end
            frame_bytes.push_back(crc[31:24]);
            frame_bytes.push_back(crc[23:16]);
            frame_bytes.push_back(crc[15:8]);
            frame_bytes.push_back(crc[7:0]);
        end
    endtask

    // One random buffer. Half are clean sections; the rest are sections with
    // a flipped bit, truncated sections, very short sections whose CRC is
    // whatever the bytes give, and plain noise.
    task automatic random_frame();
        int unsigned kind;
        int unsigned cut;
        int unsigned idx;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            build_section(pick_tid(), pick_len());
        end else if (kind < 85) begin
            build_section(pick_tid(), $urandom_range(0, 3));
        end else begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
        end
        if (kind >= 50 && kind < 65) begin
            // Damage the body or the CRC, never the header, so the length holds.
            idx = $urandom_range(3, frame_bytes.size() - 1);
            frame_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
        end else if (kind >= 65 && kind < 75) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut) begin
                void'(frame_bytes.pop_back());
            end
        end
        // Complete sections sometimes carry bytes the block must throw away.
        if ((kind < 65 || (kind >= 75 && kind < 85)) && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
        end
        send_frame();
    endtask

    // Lowers valid and waits until every predicted verdict has come back,
    // plus DrainCycles more for a trailing byte that gives no result.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // The register is only written once the block has gone quiet.
    task automatic set_check_enable(input logic en);
        wait_for_drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= en;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.check_en = en;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed buffers with the CRC check at its reset value of one.
        // A single byte and a two-byte buffer are both too short.
        frame_bytes = '{TidBat};
        send_frame();
        frame_bytes = '{TidNitActual, 8'hF0};
        send_frame();
        // Empty section: the length is zero once the upper nibble is masked.
        frame_bytes = '{TidNitOther, 8'hF0, 8'h00};
        send_frame();
        // Clean section followed by trailing bytes that must be dropped.
        build_section(TidSdtActual, 4);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        send_frame();
        // The buffer ends in the middle of the section.
        frame_bytes = '{TidSdtOther, 8'h00, 8'h06, 8'h5A};
        send_frame();
        // Clean section with an unknown table id, ending exactly on the buffer end.
        build_section(8'hFF, 4);
        send_frame();

        // Random phases, toggling the CRC check between its two settings and
        // varying the pressure. One phase runs with no gaps or stalls at all,
        // one with heavy pressure on both sides.
        for (int phase = 0; phase < PhaseCount; phase++) begin
            int unsigned phase_end;
            set_check_enable(1'(phase % 2));
            if (phase == 2) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else if (phase == 4) begin
                idle_pct  = 60;
                stall_pct = 60;
            end else begin
                idle_pct  = 25;
                stall_pct = 25;
            end
            phase_end = bytes_sent + PhaseBytes;
            // One long section, counted in this phase's byte budget.
            if (phase == 5) begin
                build_section(pick_tid(), LongSecLen);
                send_frame();
            end
            while (bytes_sent < phase_end) begin
                random_frame();
            end
        end

        wait_for_drain();
        if (tracker.fail_count == 0) begin
            $display("tb_si_section_crc_checker passed");
        end else begin
            $display("tb_si_section_crc_checker failed");
        end
        $finish;
    end

endmodule
